// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition on one edge implies another on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/hcbp_pkg.sv =====
// Types and constants for the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int WORD_W       = 32;
	localparam int LEN_W        = 6;
	localparam int SYM_W        = 8;
	localparam int KIND_W       = 2;
	localparam int BYTE_W       = 8;
	localparam int TBL_DEPTH    = 1 << SYM_W;
	localparam int ACC_W        = WORD_W + BYTE_W;
	localparam int CNT_W        = 6;
	localparam int FILL_W       = 3;
	localparam int IN_DATA_W    = 48;

	localparam int CAP_LEN = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
	localparam logic [LEN_W-1:0] CAP_LEN_L = LEN_W'(CAP_LEN);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2
	} hcbp_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DRAIN
	} hcbp_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
	} hcbp_entry_t;

	typedef struct packed {
		logic load_code;
		logic flush;
		logic drain;
	} hcbp_ctrl_t;

	typedef struct packed {
		logic sum_ge8;
		logic has_bits;
		logic emit;
		logic emit_last;
	} hcbp_stat_t;

endpackage

// ===== design/hcbp_table.sv =====
// Code table memory with per-entry valid bits; unwritten entries read as no code.
`timescale 1ns / 1ps

module hcbp_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [hcbp_pkg::SYM_W-1:0]      wr_addr,
	input  hcbp_pkg::hcbp_entry_t           wr_entry,
	input  logic                            rd_en,
	input  logic [hcbp_pkg::SYM_W-1:0]      rd_addr,
	output hcbp_pkg::hcbp_entry_t           rd_entry
);

	hcbp_pkg::hcbp_entry_t mem [hcbp_pkg::TBL_DEPTH];
	hcbp_pkg::hcbp_entry_t rd_q;
	logic [hcbp_pkg::TBL_DEPTH-1:0] valid_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry.word = rd_q.word;
	assign rd_entry.len  = rd_valid_q ? rd_q.len : '0;

endmodule

// ===== design/hcbp_packer.sv =====
// Bit accumulator, byte extraction and output register.
`timescale 1ns / 1ps

module hcbp_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hcbp_pkg::hcbp_ctrl_t              ctrl,
	input  hcbp_pkg::hcbp_entry_t             entry,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [hcbp_pkg::BYTE_W-1:0]       out_byte,
	output logic                              out_last,
	output hcbp_pkg::hcbp_stat_t              stat
);

	localparam int ACC_W  = hcbp_pkg::ACC_W;
	localparam int CNT_W  = hcbp_pkg::CNT_W;
	localparam int BYTE_W = hcbp_pkg::BYTE_W;
	localparam int WORD_W = hcbp_pkg::WORD_W;
	localparam int LEN_W  = hcbp_pkg::LEN_W;

	// acc_q is left-aligned: the oldest pending bit sits in the top position
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	logic [WORD_W-1:0] aligned;
	logic [ACC_W-1:0]  merged;
	logic [CNT_W-1:0]  sum;
	logic              emit;

	always_comb begin
		aligned = entry.word << (LEN_W'(WORD_W) - entry.len);
		merged  = {acc_q[ACC_W-1 -: BYTE_W], {WORD_W{1'b0}}}
			| ({aligned, {BYTE_W{1'b0}}} >> cnt_q[hcbp_pkg::FILL_W-1:0]);
		sum     = cnt_q + CNT_W'(entry.len);
		emit    = ctrl.drain && (cnt_q >= CNT_W'(BYTE_W)) && (!valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ctrl.load_code) begin
				acc_q <= merged;
				cnt_q <= sum;
			end else if (ctrl.flush) begin
				// pad a partial byte out to a whole one; low bits are already zero
				if (cnt_q != '0) begin
					cnt_q <= CNT_W'(BYTE_W);
				end
			end else if (emit) begin
				acc_q <= acc_q << BYTE_W;
				cnt_q <= cnt_q - CNT_W'(BYTE_W);
			end

			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= acc_q[ACC_W-1 -: BYTE_W];
			last_q <= cnt_q < CNT_W'(2 * BYTE_W);
		end
	end

	assign out_valid      = valid_q;
	assign out_byte       = byte_q;
	assign out_last       = last_q;
	assign stat.sum_ge8   = sum >= CNT_W'(BYTE_W);
	assign stat.has_bits  = cnt_q != '0;
	assign stat.emit      = emit;
	assign stat.emit_last = cnt_q < CNT_W'(2 * BYTE_W);

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// Top level: Huffman encoder, code table lookup and MSB-first byte packer.
// Load item: written to the table, no output. Flush item: pads a partial byte and drains it.
// Encode item: table read (synchronous RAM), merge in the lookup state, then one output byte per
// cycle while not stalled; bytes pass the accumulator and the output register.
// Input is taken while the last byte still waits in the output register.
// Reset clears the packer, the control state and the table valid bits (all lengths read zero).
`timescale 1ns / 1ps

module huffman_code_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] symbol, [39:8] code_word, [45:40] code_length, [47:46] zero
	input  logic [47:0] s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);

	hcbp_pkg::hcbp_state_t state_q, state_d;
	hcbp_pkg::hcbp_ctrl_t  ctrl;
	hcbp_pkg::hcbp_stat_t  stat;
	hcbp_pkg::hcbp_entry_t wr_entry, rd_entry;

	logic [hcbp_pkg::SYM_W-1:0]  symbol;
	logic [hcbp_pkg::WORD_W-1:0] code_word;
	logic [hcbp_pkg::LEN_W-1:0]  code_length;
	logic in_fire;
	logic wr_en, rd_en;

	assign symbol      = s_axis_tdata[7:0];
	assign code_word   = s_axis_tdata[39:8];
	assign code_length = s_axis_tdata[45:40];
	assign in_fire     = s_axis_tvalid && s_axis_tready;

	assign wr_entry.word = code_word;
	assign wr_entry.len  = (code_length > hcbp_pkg::CAP_LEN_L) ? hcbp_pkg::CAP_LEN_L
		: code_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hcbp_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (s_axis_tuser)
						hcbp_pkg::KIND_ENCODE: state_d = hcbp_pkg::ST_LOOKUP;
						hcbp_pkg::KIND_FLUSH: begin
							if (stat.has_bits) begin
								state_d = hcbp_pkg::ST_DRAIN;
							end
						end
						default: state_d = hcbp_pkg::ST_IDLE;
					endcase
				end
			end
			hcbp_pkg::ST_LOOKUP: begin
				state_d = stat.sum_ge8 ? hcbp_pkg::ST_DRAIN : hcbp_pkg::ST_IDLE;
			end
			hcbp_pkg::ST_DRAIN: begin
				if (stat.emit && stat.emit_last) begin
					state_d = hcbp_pkg::ST_IDLE;
				end
			end
			default: state_d = hcbp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready  = state_q == hcbp_pkg::ST_IDLE;
		ctrl.load_code = state_q == hcbp_pkg::ST_LOOKUP;
		ctrl.drain     = state_q == hcbp_pkg::ST_DRAIN;
		ctrl.flush     = in_fire && (s_axis_tuser == hcbp_pkg::KIND_FLUSH);
		wr_en          = in_fire && (s_axis_tuser == hcbp_pkg::KIND_LOAD);
		rd_en          = in_fire && (s_axis_tuser == hcbp_pkg::KIND_ENCODE);
	end

	hcbp_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (symbol),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (symbol),
		.rd_entry (rd_entry)
	);

	hcbp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.entry     (rd_entry),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.stat      (stat)
	);

endmodule

// ===== design/hcbp_checker.sv =====
// Port-level checks for the Huffman code bit packer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [47:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);

	logic in_fire;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// a waiting item holds its byte and marker
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")

	// a table load completes in its own cycle
	`ASSERT_NEXT(a_load_one_cycle, clk, arst_n, in_fire && s_axis_tuser == hcbp_pkg::KIND_LOAD, s_axis_tready, "input not ready after a table load")

	// an encode always needs the table read cycle
	`ASSERT_NEXT(a_encode_lookup, clk, arst_n, in_fire && s_axis_tuser == hcbp_pkg::KIND_ENCODE, !s_axis_tready, "encode did not wait for the table read")

	// new output bytes appear only while input is held off
	`ASSERT_CLK(a_emit_when_busy, clk, arst_n, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "output byte produced while input was open")

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the Huffman code bit packer: table loads, encodes, flushes.
`timescale 1ns / 1ps

module tb;

	// kind value with no meaning; the block must ignore it
	localparam logic [hcbp_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [hcbp_pkg::BYTE_W-1:0] data;
		logic                        last;
	} out_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;

	// predictor state
	hcbp_pkg::hcbp_entry_t       code_tbl [hcbp_pkg::TBL_DEPTH];
	logic [hcbp_pkg::BYTE_W-1:0] acc_byte;
	int                          acc_fill;
	out_beat_t                   expected_bytes [$];

	int  fail_count;
	bit  tx_steady;
	bit  rx_steady;

	huffman_code_bit_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Works out the bytes one accepted item causes and queues them.
	task automatic pack_predict(input logic [hcbp_pkg::KIND_W-1:0] kind,
			input logic [hcbp_pkg::SYM_W-1:0] sym,
			input logic [hcbp_pkg::WORD_W-1:0] word,
			input logic [hcbp_pkg::LEN_W-1:0] len);
		logic [hcbp_pkg::BYTE_W-1:0] made [4];
		hcbp_pkg::hcbp_entry_t       ent;
		int                          n;
		int                          i;
		n = 0;
		case (kind)
			hcbp_pkg::KIND_LOAD: begin
				ent.word = word;
				ent.len  = (len > hcbp_pkg::CAP_LEN_L) ? hcbp_pkg::CAP_LEN_L : len;
				code_tbl[sym] = ent;
			end
			hcbp_pkg::KIND_ENCODE: begin
				ent = code_tbl[sym];
				for (i = int'(ent.len); i > 0; i--) begin
					if (ent.word[i-1])
						acc_byte[7-acc_fill] = 1'b1;
					acc_fill++;
					if (acc_fill == 8) begin
						made[n] = acc_byte;
						n++;
						acc_byte = '0;
						acc_fill = 0;
					end
				end
			end
			hcbp_pkg::KIND_FLUSH: begin
				if (acc_fill > 0) begin
					made[n] = acc_byte;
					n++;
				end
				acc_byte = '0;
				acc_fill = 0;
			end
			default: ;
		endcase
		for (i = 0; i < n; i++)
			expected_bytes.push_back('{data: made[i], last: (i == n - 1)});
	endtask

	task automatic report_mismatch(input string what, input logic [8:0] want, input logic [8:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %0s at %0t: expected %h, got %h", what, $realtime, want, got);
	endtask

	// Holds one item on the input until it is taken, then predicts it.
	task automatic drive_item(input logic [hcbp_pkg::KIND_W-1:0] kind,
			input logic [hcbp_pkg::SYM_W-1:0] sym,
			input logic [hcbp_pkg::WORD_W-1:0] word,
			input logic [hcbp_pkg::LEN_W-1:0] len);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, len, word, sym};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pack_predict(kind, sym, word, len);
	endtask

	// Symbols with a length of zero (all of them after reset), empty flush, spare kind.
	task automatic test_empty_table;
		drive_item(hcbp_pkg::KIND_ENCODE, 8'h00, '0, '0);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		drive_item(hcbp_pkg::KIND_FLUSH, 8'h00, '0, '0);
		drive_item(KIND_SPARE, 8'h5A, 32'hDEAD_BEEF, 6'd12);
	endtask

	// Widest and narrowest codes, saturating lengths, bits above the length.
	task automatic test_code_extremes;
		drive_item(hcbp_pkg::KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
		drive_item(hcbp_pkg::KIND_LOAD, 8'hFF, 32'hFFFF_FFFE, 6'd1);
		drive_item(hcbp_pkg::KIND_LOAD, 8'hA5, 32'h1234_5678, 6'd63);
		drive_item(hcbp_pkg::KIND_LOAD, 8'h5A, 32'h8000_0001, 6'd33);
		drive_item(hcbp_pkg::KIND_LOAD, 8'h3C, 32'hFFFF_FF55, 6'd7);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'h00, '0, '0);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'hFF, '0, '0);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'hA5, '0, '0);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'h5A, '0, '0);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'h3C, '0, '0);
		drive_item(hcbp_pkg::KIND_FLUSH, 8'h00, '0, '0);
		// second flush finds the packer empty
		drive_item(hcbp_pkg::KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		drive_item(KIND_SPARE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'h3C, '0, '0);
		// clearing an entry back to no code
		drive_item(hcbp_pkg::KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
		drive_item(hcbp_pkg::KIND_ENCODE, 8'h00, '0, '0);
		drive_item(hcbp_pkg::KIND_FLUSH, 8'h00, '0, '0);
	endtask

	// Streams of loads, encodes and, most of the time, a flush, with some noise in between.
	task automatic test_random_streams(input int target);
		int                         sent;
		int                         n_codes;
		int                         n_syms;
		int                         k;
		logic [hcbp_pkg::SYM_W-1:0] sym;
		logic [hcbp_pkg::LEN_W-1:0] len;
		logic [hcbp_pkg::SYM_W-1:0] loaded [$];
		sent = 0;
		while (sent < target) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			loaded.delete();
			n_codes = $urandom_range(2, 10);
			for (k = 0; k < n_codes; k++) begin
				sym = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 15))
					0:       len = '0;
					1, 2:    len = 6'($urandom_range(13, 63));
					default: len = 6'($urandom_range(1, 12));
				endcase
				drive_item(hcbp_pkg::KIND_LOAD, sym, $urandom, len);
				loaded.push_back(sym);
				sent++;
			end
			n_syms = $urandom_range(3, 16);
			for (k = 0; k < n_syms; k++) begin
				if ($urandom_range(0, 9) == 0)
					sym = 8'($urandom_range(0, 255));
				else
					sym = loaded[$urandom_range(0, loaded.size() - 1)];
				drive_item(hcbp_pkg::KIND_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
				sent++;
				if ($urandom_range(0, 19) == 0)
					drive_item(KIND_SPARE, 8'($urandom_range(0, 255)), $urandom,
						6'($urandom_range(0, 63)));
			end
			if ($urandom_range(0, 4) != 0) begin
				drive_item(hcbp_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)), $urandom,
					6'($urandom_range(0, 63)));
				sent++;
			end
		end
		drive_item(hcbp_pkg::KIND_FLUSH, 8'h00, '0, '0);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Result checker
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected byte", 9'h000, {m_axis_tdata, m_axis_tlast});
			end else begin
				want = expected_bytes.pop_front();
				if (m_axis_tdata !== want.data)
					report_mismatch("out_byte", {1'b0, want.data}, {1'b0, m_axis_tdata});
				if (m_axis_tlast !== want.last)
					report_mismatch("last_of_run", {8'h00, want.last}, {8'h00, m_axis_tlast});
			end
		end
	end

	// Receiver: random stall before each item
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_steady ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		fail_count    = 0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		acc_byte      = '0;
		acc_fill      = 0;
		for (int i = 0; i < hcbp_pkg::TBL_DEPTH; i++)
			code_tbl[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_code_extremes();
		test_random_streams(115);

		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_bytes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
